### src/positional_list_insert_delete_macros.svh
// Assertion macros used by the positional list top level.
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define PLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PLID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/plid_pkg.sv
// Types and constants of the positional list.
package plid_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 8;
  localparam int LEN_W         = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_BEYOND  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic                     command;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         length;
  } rsp_t;

  typedef struct packed {
    logic ins;
    logic del;
  } op_t;

endpackage

### src/plid_cell.sv
// One list slot: keeps its entry, or takes it from a neighbor or the request.
module plid_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 4
) (
  input  logic                              clk,
  input  plid_pkg::op_t                     op,
  input  logic [IW-1:0]                     idx,
  input  logic signed [plid_pkg::DATA_W-1:0] value,
  input  logic signed [plid_pkg::DATA_W-1:0] left_data,
  input  logic signed [plid_pkg::DATA_W-1:0] right_data,
  output logic signed [plid_pkg::DATA_W-1:0] data
);

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (MY_INDEX > idx) begin
        data <= left_data;
      end else if (MY_INDEX == idx) begin
        data <= value;
      end
    end else if (op.del) begin
      if (MY_INDEX >= idx) begin
        data <= right_data;
      end
    end
  end

endmodule

### src/positional_list_insert_delete.sv
// Top level of the positional insert/delete list built from a row of slot cells.
//
//   channel   direction  handshake                       payload
//   request   in         start high and busy low         request (plid_pkg::req_t)
//   result    out        done high for one cycle         result  (plid_pkg::rsp_t)
//
// One request is taken in every cycle while busy is low; its result is registered and appears in the cycle after.
// Every slot compares its own index with the position and shifts in the same cycle.
// Busy is high only while reset is asserted.
// Reset clears the entry count; slot contents stay undefined until written.
// The receiver cannot stall, so nothing ever holds a result back.
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete #(
  parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  plid_pkg::req_t   request,
  output logic             done,
  output plid_pkg::rsp_t   result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW = ((CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W) + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic                               accept;
  logic signed [WW-1:0]               pos_w;
  logic signed [WW-1:0]               pos_m1;
  logic signed [WW-1:0]               cnt_w;
  logic                               ins_ok;
  logic                               del_ok;
  logic [IW-1:0]                      idx;
  plid_pkg::op_t                      op;
  plid_pkg::status_t                  status_next;
  logic signed [plid_pkg::DATA_W-1:0] removed_next;
  logic signed [plid_pkg::DATA_W-1:0] cell_q [DEPTH];

  assign busy   = rst;
  assign accept = start && !busy;
  assign pos_w  = WW'(request.position);
  assign pos_m1 = pos_w - WW'(1);
  assign cnt_w  = WW'(count);

  always_comb begin
    status_next = plid_pkg::ST_OK;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    if (request.command == plid_pkg::CMD_INSERT) begin
      if (pos_w < 0) begin
        status_next = plid_pkg::ST_INVALID;
      end else if (pos_w > cnt_w) begin
        status_next = plid_pkg::ST_BEYOND;
      end else if (count == FULL_COUNT) begin
        status_next = plid_pkg::ST_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_next = plid_pkg::ST_EMPTY;
      end else if (pos_w <= 0 || pos_w > cnt_w) begin
        status_next = plid_pkg::ST_INVALID;
      end else begin
        del_ok = 1'b1;
      end
    end
  end

  assign idx    = (request.command == plid_pkg::CMD_DELETE) ? pos_m1[IW-1:0] : pos_w[IW-1:0];
  assign op.ins = accept && ins_ok;
  assign op.del = accept && del_ok;
  assign removed_next = del_ok ? cell_q[idx] : '0;

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CW'(1);
    end else if (op.del) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [plid_pkg::DATA_W-1:0] left_data;
    logic signed [plid_pkg::DATA_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_q[i+1];
    end
    plid_cell #(
      .INDEX (i),
      .IW    (IW)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .idx        (idx),
      .value      (request.value_in),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status        <= status_next;
      result.removed_value <= removed_next;
      result.length        <= plid_pkg::LEN_W'(count_next);
    end
  end

  `PLID_ASSERT_ALWAYS(a_count_bound, rst || count <= FULL_COUNT, "entry count exceeds depth")
  `PLID_ASSERT(a_done_follows, done == $past(start && !busy), "done does not follow a request")
  `PLID_ASSERT(a_len_match, done |-> result.length == plid_pkg::LEN_W'(count), "length mismatch")
  `PLID_ASSERT(a_fail_keeps, done && result.status != plid_pkg::ST_OK |-> count == $past(count),
    "failed request changed the count")
  `PLID_ASSERT(a_count_moves, count != $past(count) |-> done, "count changed without a result")

endmodule

### dv/tb.sv
// Self-checking testbench for the positional insert/delete list.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 1550;

  class list_scoreboard;
    logic signed [plid_pkg::DATA_W-1:0] contents[$];
    plid_pkg::rsp_t pending_results[$];
    int errors;
    int checked;
    int status_hits[5];
    int peak_length;

    function void note_request(plid_pkg::req_t r);
      plid_pkg::rsp_t want;
      int pos;
      pos = $signed(r.position);
      want.status = plid_pkg::ST_OK;
      want.removed_value = '0;
      if (r.command == plid_pkg::CMD_INSERT) begin
        if (pos < 0) want.status = plid_pkg::ST_INVALID;
        else if (pos > contents.size()) want.status = plid_pkg::ST_BEYOND;
        else if (contents.size() >= plid_pkg::DEPTH_DEFAULT) want.status = plid_pkg::ST_FULL;
        else contents.insert(pos, r.value_in);
      end else begin
        if (contents.size() == 0) want.status = plid_pkg::ST_EMPTY;
        else if (pos <= 0 || pos > contents.size()) want.status = plid_pkg::ST_INVALID;
        else begin
          want.removed_value = contents[pos-1];
          contents.delete(pos-1);
        end
      end
      want.length = plid_pkg::LEN_W'(contents.size());
      if (contents.size() > peak_length) peak_length = contents.size();
      status_hits[want.status]++;
      pending_results.push_back(want);
    endfunction

    function void check_result(plid_pkg::rsp_t got);
      plid_pkg::rsp_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d removed %0d length %0d",
                 $time, got.status, got.removed_value, got.length);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.removed_value !== want.removed_value) begin
        $display("%0t: removed_value expected %0d actual %0d",
                 $time, want.removed_value, got.removed_value);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (pending_results.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  plid_pkg::req_t request;
  logic done;
  plid_pkg::rsp_t result;

  list_scoreboard sb;

  positional_list_insert_delete u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(request);
      if (done) sb.check_result(result);
    end
  end

  function automatic plid_pkg::req_t make_request(logic cmd, int pos,
                                                  logic [plid_pkg::DATA_W-1:0] val);
    plid_pkg::req_t r;
    r.command = cmd;
    r.position = plid_pkg::POS_W'(pos);
    r.value_in = val;
    return r;
  endfunction

  // Mostly legal positions for the current length, with some noise across the whole range.
  function automatic plid_pkg::req_t random_request(int insert_pct);
    plid_pkg::req_t r;
    int len;
    logic [plid_pkg::DATA_W-1:0] val;
    len = sb.contents.size();
    case ($urandom_range(0, 7))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      default: val = $urandom;
    endcase
    if ($urandom_range(0, 99) < 15) begin
      r.command = 1'($urandom_range(0, 1));
      r.position = plid_pkg::POS_W'($urandom_range(0, 255));
      r.value_in = val;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      case ($urandom_range(0, 3))
        0: r = make_request(plid_pkg::CMD_INSERT, 0, val);
        1: r = make_request(plid_pkg::CMD_INSERT, len, val);
        default: r = make_request(plid_pkg::CMD_INSERT, $urandom_range(0, len), val);
      endcase
    end else begin
      r = make_request(plid_pkg::CMD_DELETE, (len == 0) ? 1 : $urandom_range(1, len), $urandom);
    end
    return r;
  endfunction

  task automatic send_request(input plid_pkg::req_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    plid_pkg::req_t directed[$];
    int sent;
    int burst;
    int seg_left;
    int insert_pct;
    int wait_cycles;

    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_request(plid_pkg::CMD_DELETE, 1, 32'h1));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 0, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, -128, 32'hffff_ffff));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, 1, 32'h5));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, 0, 32'h7fff_ffff));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, 1, 32'h8000_0000));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, 1, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_INSERT, 127, 32'h1234_5678));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 0, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, -1, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, -128, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 4, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 127, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 2, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 2, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 1, 32'h0));
    directed.push_back(make_request(plid_pkg::CMD_DELETE, 1, 32'h0));
    foreach (directed[i]) send_request(directed[i]);
    hold_until_drained();

    // Fill to full, probe the full list at a legal and an illegal position, then delete the last entry.
    for (int i = 0; i < plid_pkg::DEPTH_DEFAULT; i++) begin
      send_request(make_request(plid_pkg::CMD_INSERT, i, $urandom));
    end
    send_request(make_request(plid_pkg::CMD_INSERT, 3, 32'hdead_beef));
    send_request(make_request(plid_pkg::CMD_INSERT, plid_pkg::DEPTH_DEFAULT + 1, 32'h0));
    send_request(make_request(plid_pkg::CMD_DELETE, plid_pkg::DEPTH_DEFAULT, 32'h0));
    hold_until_drained();

    sent = 0;
    seg_left = 0;
    insert_pct = 50;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          case ($urandom_range(0, 2))
            0: insert_pct = 90;
            1: insert_pct = 50;
            default: insert_pct = 10;
          endcase
        end
        send_request(random_request(insert_pct));
        seg_left--;
        sent++;
        if (sent % 400 == 0) hold_until_drained();
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    sb.report_leftovers();

    $display("Checked %0d results; peak list length %0d of %0d.",
             sb.checked, sb.peak_length, plid_pkg::DEPTH_DEFAULT);
    $display("Outcomes: ok %0d, invalid %0d, beyond end %0d, empty %0d, full %0d.",
             sb.status_hits[plid_pkg::ST_OK], sb.status_hits[plid_pkg::ST_INVALID],
             sb.status_hits[plid_pkg::ST_BEYOND], sb.status_hits[plid_pkg::ST_EMPTY],
             sb.status_hits[plid_pkg::ST_FULL]);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
